/* rtl/core/mi3_pkg.sv */
`default_nettype none
package mi3_pkg;

  // element and intermediate widths
  localparam int ElemW = 16;
  localparam int ProdW = 32;
  localparam int CofW  = 33;
  localparam int DetW  = 49;
  localparam int InvW  = 32;

  // quotient bits formed by the divider lanes, one per stage
  localparam int QuoW = 33;

  // cycles through the cofactor/determinant front end
  localparam int FrontLat = 5;
  // setup + one stage per quotient bit + saturation
  localparam int LaneLat  = QuoW + 2;

  typedef logic signed [ElemW-1:0] elem_t;
  typedef logic signed [CofW-1:0]  cof_t;
  typedef logic signed [DetW-1:0]  det_t;
  typedef logic signed [InvW-1:0]  inv_t;

  // result of one divider lane
  typedef struct packed {
    logic valid;
    logic clip;
    inv_t quo;
  } lane_out_t;

endpackage
`default_nettype wire

/* rtl/core/mi3_cofactor.sv */
`default_nettype none
module mi3_cofactor import mi3_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  in_valid,
  input  wire elem_t a [9],
  output logic       out_valid,
  output cof_t       cof [9],
  output det_t       det
);

  // a[] index is col*3+row
  logic                    v1, v2, v3, v4, v5;
  elem_t                   m [9];
  logic signed [ProdW-1:0] p [18];
  cof_t                    c3 [9];
  cof_t                    c4 [9];
  logic signed [DetW-1:0]  dp [3];
  elem_t                   ma [3];
  elem_t                   a0 [3];

  // valid pipeline
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0; v2 <= 1'b0; v3 <= 1'b0; v4 <= 1'b0; v5 <= 1'b0;
    end else begin
      v1 <= in_valid; v2 <= v1; v3 <= v2; v4 <= v3; v5 <= v4;
    end
  end

  // stage 1: capture matrix
  always_ff @(posedge clk) begin
    for (int i = 0; i < 9; i++) m[i] <= a[i];
  end

  // stage 2: the eighteen 2x2 products
  always_ff @(posedge clk) begin
    p[0]  <= m[4] * m[8];  p[1]  <= m[5] * m[7];
    p[2]  <= m[3] * m[8];  p[3]  <= m[5] * m[6];
    p[4]  <= m[3] * m[7];  p[5]  <= m[4] * m[6];
    p[6]  <= m[1] * m[8];  p[7]  <= m[2] * m[7];
    p[8]  <= m[0] * m[8];  p[9]  <= m[2] * m[6];
    p[10] <= m[0] * m[7];  p[11] <= m[1] * m[6];
    p[12] <= m[1] * m[5];  p[13] <= m[2] * m[4];
    p[14] <= m[0] * m[5];  p[15] <= m[2] * m[3];
    p[16] <= m[0] * m[4];  p[17] <= m[1] * m[3];
    // first column travels with its products
    ma[0] <= m[0]; ma[1] <= m[1]; ma[2] <= m[2];
  end

  // stage 3: signed cofactors, laid out as inverse [col][row]
  always_ff @(posedge clk) begin
    c3[0] <= CofW'(p[0])  - CofW'(p[1]);
    c3[3] <= CofW'(p[3])  - CofW'(p[2]);
    c3[6] <= CofW'(p[4])  - CofW'(p[5]);
    c3[1] <= CofW'(p[7])  - CofW'(p[6]);
    c3[4] <= CofW'(p[8])  - CofW'(p[9]);
    c3[7] <= CofW'(p[11]) - CofW'(p[10]);
    c3[2] <= CofW'(p[12]) - CofW'(p[13]);
    c3[5] <= CofW'(p[15]) - CofW'(p[14]);
    c3[8] <= CofW'(p[16]) - CofW'(p[17]);
    a0[0] <= ma[0]; a0[1] <= ma[1]; a0[2] <= ma[2];
  end

  // stage 4: first-column expansion products
  always_ff @(posedge clk) begin
    dp[0] <= DetW'(a0[0]) * DetW'(c3[0]);
    dp[1] <= DetW'(a0[1]) * DetW'(c3[3]);
    dp[2] <= DetW'(a0[2]) * DetW'(c3[6]);
    for (int i = 0; i < 9; i++) c4[i] <= c3[i];
  end

  // stage 5: determinant sum
  always_ff @(posedge clk) begin
    det <= dp[0] + dp[1] + dp[2];
    for (int i = 0; i < 9; i++) cof[i] <= c4[i];
  end

  assign out_valid = v5;

endmodule
`default_nettype wire

/* rtl/core/mi3_div_lane.sv */
`default_nettype none
module mi3_div_lane import mi3_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  input  wire cof_t num,
  input  wire det_t den,
  output lane_out_t res
);

  // restoring divider, one quotient bit per stage, on magnitudes
  logic [CofW-1:0] mag_n;
  logic [DetW-1:0] mag_d;
  logic            ovf_c;

  logic            v    [QuoW+1];
  logic [DetW-1:0] rem  [QuoW+1];
  logic [DetW-1:0] dd   [QuoW+1];
  logic [QuoW-1:0] feed [QuoW+1];
  logic [QuoW-1:0] q    [QuoW+1];
  logic            neg  [QuoW+1];
  logic            ovf  [QuoW+1];
  logic            zer  [QuoW+1];

  always_comb begin
    mag_n = num[CofW-1] ? CofW'(-num) : CofW'(num);
    mag_d = den[DetW-1] ? DetW'(-den) : DetW'(den);
    // quotient reaches 2^33 when the top of the numerator covers the divisor
    ovf_c = DetW'(mag_n[CofW-1:5]) >= mag_d;
  end

  // setup stage
  always_ff @(posedge clk) begin
    if (rst) v[0] <= 1'b0;
    else     v[0] <= in_valid;
    rem[0]  <= DetW'(mag_n[CofW-1:5]);
    dd[0]   <= mag_d;
    feed[0] <= {mag_n[4:0], 28'd0};
    q[0]    <= '0;
    neg[0]  <= num[CofW-1] ^ den[DetW-1];
    ovf[0]  <= ovf_c;
    zer[0]  <= (den == '0);
  end

  // quotient steps
  for (genvar k = 0; k < QuoW; k++) begin : g_step
    logic [DetW:0] t;
    logic          ge;
    always_comb begin
      t  = {rem[k], feed[k][QuoW-1]};
      ge = t >= {1'b0, dd[k]};
    end
    always_ff @(posedge clk) begin
      if (rst) v[k+1] <= 1'b0;
      else     v[k+1] <= v[k];
      rem[k+1]  <= ge ? DetW'(t - {1'b0, dd[k]}) : DetW'(t);
      dd[k+1]   <= dd[k];
      feed[k+1] <= {feed[k][QuoW-2:0], 1'b0};
      q[k+1]    <= {q[k][QuoW-2:0], ge};
      neg[k+1]  <= neg[k];
      ovf[k+1]  <= ovf[k];
      zer[k+1]  <= zer[k];
    end
  end

  // sign and saturation
  logic [QuoW-1:0] qf;
  logic            sat;
  always_comb begin
    qf  = q[QuoW];
    sat = ovf[QuoW] || (neg[QuoW] ? (qf > QuoW'(33'h080000000))
                                  : (qf > QuoW'(33'h07FFFFFFF)));
  end

  always_ff @(posedge clk) begin
    if (rst) res.valid <= 1'b0;
    else     res.valid <= v[QuoW];
    if (zer[QuoW]) begin
      res.quo  <= '0;
      res.clip <= 1'b0;
    end else if (sat) begin
      res.quo  <= neg[QuoW] ? 32'sh80000000 : 32'sh7FFFFFFF;
      res.clip <= 1'b1;
    end else begin
      res.quo  <= neg[QuoW] ? InvW'(-qf) : InvW'(qf);
      res.clip <= 1'b0;
    end
  end

endmodule
`default_nettype wire

/* rtl/core/matrix3x3_inverse.sv */
// done follows start through 40 register
// stages in all (5 cofactor/determinant, 35 divider lanes).
// Throughput: one word per cycle; nine 33-stage restoring dividers run side by side.
// busy is always low; the receiver cannot stall, each result shows for one cycle.
// Synchronous active-high reset clears the valid pipeline only.
`default_nettype none
module matrix3x3_inverse import mi3_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic start,
  output logic      busy,
  input  wire elem_t in_c0_r0, in_c0_r1, in_c0_r2,
  input  wire elem_t in_c1_r0, in_c1_r1, in_c1_r2,
  input  wire elem_t in_c2_r0, in_c2_r1, in_c2_r2,
  output logic      done,
  output inv_t      inv_c0_r0, inv_c0_r1, inv_c0_r2,
  output inv_t      inv_c1_r0, inv_c1_r1, inv_c1_r2,
  output inv_t      inv_c2_r0, inv_c2_r1, inv_c2_r2,
  output det_t      det_value,
  output logic      singular,
  output logic      clipped
);

  elem_t     a [9];
  cof_t      cof [9];
  det_t      det;
  logic      f_valid;
  lane_out_t lo [9];
  det_t      det_d [LaneLat];

  assign busy = 1'b0;
  assign a = '{in_c0_r0, in_c0_r1, in_c0_r2, in_c1_r0, in_c1_r1, in_c1_r2,
               in_c2_r0, in_c2_r1, in_c2_r2};

  mi3_cofactor u_cof (
    .clk, .rst, .in_valid(start), .a, .out_valid(f_valid), .cof, .det
  );

  for (genvar i = 0; i < 9; i++) begin : g_lane
    mi3_div_lane u_lane (
      .clk, .rst, .in_valid(f_valid), .num(cof[i]), .den(det), .res(lo[i])
    );
  end

  // determinant rides alongside the lanes
  always_ff @(posedge clk) begin
    det_d[0] <= det;
    for (int i = 1; i < LaneLat; i++) det_d[i] <= det_d[i-1];
  end

  // result word
  assign done      = lo[0].valid;
  assign inv_c0_r0 = lo[0].quo; assign inv_c0_r1 = lo[1].quo; assign inv_c0_r2 = lo[2].quo;
  assign inv_c1_r0 = lo[3].quo; assign inv_c1_r1 = lo[4].quo; assign inv_c1_r2 = lo[5].quo;
  assign inv_c2_r0 = lo[6].quo; assign inv_c2_r1 = lo[7].quo; assign inv_c2_r2 = lo[8].quo;
  assign det_value = det_d[LaneLat-1];
  assign singular  = (det_d[LaneLat-1] == '0);
  assign clipped   = lo[0].clip | lo[1].clip | lo[2].clip | lo[3].clip | lo[4].clip
                   | lo[5].clip | lo[6].clip | lo[7].clip | lo[8].clip;

  // checks
  a_no_busy: assert property (@(posedge clk) !busy)
    else $error("busy raised");
  a_sing_noclip: assert property (@(posedge clk) disable iff (rst)
    done && singular |-> !clipped) else $error("clip on singular word");
  a_sing_zero: assert property (@(posedge clk) disable iff (rst)
    done && singular |-> inv_c0_r0 == 0 && inv_c1_r1 == 0 && inv_c2_r2 == 0)
    else $error("singular word not zero");
  a_lanes_agree: assert property (@(posedge clk) disable iff (rst)
    lo[0].valid == lo[8].valid) else $error("lanes out of step");

endmodule
`default_nettype wire

/* sim/matrix3x3_inverse_test.sv */
`timescale 1ns / 1ps
module matrix3x3_inverse_test;
  import mi3_pkg::*;

  typedef struct {
    logic signed [15:0] m [9];
  } matrix_t;

  typedef struct {
    logic signed [31:0] inv [9];
    logic signed [48:0] det;
    logic sing;
    logic clip;
  } inverse_t;

  logic clk = 0;
  logic rst = 1;
  logic start = 0;
  logic busy;
  elem_t e [9];
  logic done;
  inv_t q [9];
  det_t det_value;
  logic singular, clipped;

  matrix_t pending_mats [$];
  inverse_t expected_invs [$];
  matrix_t cur_mat;
  int errors = 0;
  bit stim_done = 0;
  bit quiet = 0;
  int gap = 0;

  initial for (int i = 0; i < 9; i++) e[i] = '0;

  matrix3x3_inverse dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .in_c0_r0(e[0]), .in_c0_r1(e[1]), .in_c0_r2(e[2]),
    .in_c1_r0(e[3]), .in_c1_r1(e[4]), .in_c1_r2(e[5]),
    .in_c2_r0(e[6]), .in_c2_r1(e[7]), .in_c2_r2(e[8]),
    .done(done),
    .inv_c0_r0(q[0]), .inv_c0_r1(q[1]), .inv_c0_r2(q[2]),
    .inv_c1_r0(q[3]), .inv_c1_r1(q[4]), .inv_c1_r2(q[5]),
    .inv_c2_r0(q[6]), .inv_c2_r1(q[7]), .inv_c2_r2(q[8]),
    .det_value(det_value), .singular(singular), .clipped(clipped)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // adjugate over determinant, Q4.28, truncated and saturated
  function automatic inverse_t invert(matrix_t mx);
    longint a [3][3];
    longint cf [3][3];
    longint d, v;
    inverse_t r;
    for (int c = 0; c < 3; c++)
      for (int k = 0; k < 3; k++) a[c][k] = mx.m[c*3+k];
    cf[0][0] =   a[1][1]*a[2][2] - a[1][2]*a[2][1];
    cf[1][0] = -(a[1][0]*a[2][2] - a[1][2]*a[2][0]);
    cf[2][0] =   a[1][0]*a[2][1] - a[1][1]*a[2][0];
    cf[0][1] = -(a[0][1]*a[2][2] - a[0][2]*a[2][1]);
    cf[1][1] =   a[0][0]*a[2][2] - a[0][2]*a[2][0];
    cf[2][1] = -(a[0][0]*a[2][1] - a[0][1]*a[2][0]);
    cf[0][2] =   a[0][1]*a[1][2] - a[0][2]*a[1][1];
    cf[1][2] = -(a[0][0]*a[1][2] - a[0][2]*a[1][0]);
    cf[2][2] =   a[0][0]*a[1][1] - a[0][1]*a[1][0];
    d = a[0][0]*cf[0][0] + a[0][1]*cf[1][0] + a[0][2]*cf[2][0];
    r.clip = 0;
    for (int c = 0; c < 3; c++)
      for (int k = 0; k < 3; k++) begin
        v = 0;
        // |cofactor| < 2^31, so cofactor * 2^28 fits in 64 bits
        if (d != 0) v = (cf[c][k] * 64'sd268435456) / d;
        if (v > 64'sd2147483647) begin
          v = 64'sd2147483647; r.clip = 1;
        end else if (v < -64'sd2147483648) begin
          v = -64'sd2147483648; r.clip = 1;
        end
        r.inv[c*3+k] = v[31:0];
      end
    r.det = d[48:0];
    r.sing = (d == 0);
    return r;
  endfunction

  function automatic logic signed [15:0] rand_elem(int mode);
    case (mode)
      0: return 16'($urandom);
      1: return 16'($signed($urandom_range(0, 8192)) - 4096);
      2: return ($urandom_range(0, 1)) ? 16'sh7fff : 16'sh8000;
      default: return 16'($signed($urandom_range(0, 16)) - 8);
    endcase
  endfunction

  task automatic push_mat(matrix_t mx);
    pending_mats.push_back(mx);
  endtask

  // stimulus
  initial begin
    matrix_t mx;
    int mode;
    // zero, identity, extremes, singular and clipping cases
    for (int i = 0; i < 9; i++) mx.m[i] = 0;
    push_mat(mx);
    for (int i = 0; i < 9; i++) mx.m[i] = (i % 4 == 0) ? 16'sd4096 : 16'sd0;
    push_mat(mx);
    for (int i = 0; i < 9; i++) mx.m[i] = (i % 4 == 0) ? 16'sh7fff : 16'sd0;
    push_mat(mx);
    for (int i = 0; i < 9; i++) mx.m[i] = (i % 4 == 0) ? 16'sh8000 : 16'sd0;
    push_mat(mx);
    for (int i = 0; i < 9; i++) mx.m[i] = (i % 4 == 0) ? 16'sd1 : 16'sd0;
    push_mat(mx);
    for (int i = 0; i < 9; i++) mx.m[i] = (i % 4 == 0) ? -16'sd1 : 16'sd0;
    push_mat(mx);
    for (int i = 0; i < 9; i++) mx.m[i] = 16'sh7fff;
    push_mat(mx);
    for (int i = 0; i < 9; i++) mx.m[i] = 16'sh8000;
    push_mat(mx);
    for (int i = 0; i < 9; i++) mx.m[i] = (i[0]) ? 16'sh8000 : 16'sh7fff;
    push_mat(mx);
    for (int i = 0; i < 9; i++) mx.m[i] = 16'(i + 1);
    push_mat(mx);
    for (int i = 0; i < 9; i++) mx.m[i] = (i == 0 || i == 4 || i == 8) ? 16'sd1 : 16'sd0;
    mx.m[3] = 16'sh7fff;
    push_mat(mx);
    for (int i = 0; i < 9; i++) mx.m[i] = (i == 2 || i == 4 || i == 6) ? 16'sd4096 : 16'sd0;
    push_mat(mx);
    for (int i = 0; i < 9; i++) mx.m[i] = (i == 2 || i == 4 || i == 6) ? 16'sh8000 : 16'sh7fff;
    push_mat(mx);
    for (int n = 0; n < 1550; n++) begin
      mode = $urandom_range(0, 5);
      for (int i = 0; i < 9; i++) mx.m[i] = rand_elem(mode > 3 ? $urandom_range(0, 3) : mode);
      // duplicate a column now and then for singular matrices
      if ($urandom_range(0, 15) == 0) for (int i = 0; i < 3; i++) mx.m[3+i] = mx.m[i];
      push_mat(mx);
    end
    repeat (10) @(posedge clk);
    rst <= 0;
  end

  // driver
  always @(posedge clk) begin
    matrix_t mx;
    if (rst) begin
      start <= 0;
    end else if (gap > 0) begin
      gap <= gap - 1;
      start <= 0;
    end else if (start && busy) begin
      // hold word
    end else if (pending_mats.size() > 0) begin
      if (start) expected_invs.push_back(invert(cur_mat));
      if (!quiet && pending_mats.size() < 200) quiet <= 1;
      if (!quiet && $urandom_range(0, 9) == 0) begin
        gap <= $urandom_range(1, 16) - 1;
        start <= 0;
      end else begin
        mx = pending_mats.pop_front();
        cur_mat <= mx;
        for (int i = 0; i < 9; i++) e[i] <= mx.m[i];
        start <= 1;
      end
    end else begin
      if (start) expected_invs.push_back(invert(cur_mat));
      start <= 0;
      stim_done <= 1;
    end
  end

  // monitor
  always @(posedge clk) begin
    inverse_t x;
    if (!rst && done) begin
      if (expected_invs.size() == 0) begin
        $error("result with no expectation");
        errors++;
      end else begin
        x = expected_invs.pop_front();
        for (int i = 0; i < 9; i++)
          if (q[i] !== x.inv[i]) begin
            $error("inv_c%0d_r%0d expected %0d got %0d", i / 3, i % 3, x.inv[i], q[i]);
            errors++;
          end
        if (det_value !== x.det) begin
          $error("det_value expected %0d got %0d", x.det, det_value);
          errors++;
        end
        if (singular !== x.sing) begin
          $error("singular expected %0d got %0d", x.sing, singular);
          errors++;
        end
        if (clipped !== x.clip) begin
          $error("clipped expected %0d got %0d", x.clip, clipped);
          errors++;
        end
      end
    end
  end

  // end of run
  initial begin
    wait (stim_done);
    wait (expected_invs.size() == 0);
    repeat (60) @(posedge clk);
    if (errors == 0 && expected_invs.size() == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

  initial begin
    #2000000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule

/* matrix3x3_inverse.f */
rtl/core/mi3_pkg.sv
rtl/core/mi3_cofactor.sv
rtl/core/mi3_div_lane.sv
rtl/core/matrix3x3_inverse.sv
sim/matrix3x3_inverse_test.sv
